### rtl/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared widths, constants, pipeline payload types and the restoring
// division step for the RGB to HSI percent converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

	localparam int CH_W   = 8;   // channel byte
	localparam int PCT_W  = 7;   // percent result
	localparam int SUM_W  = 10;  // r+g+b up to 765
	localparam int DEN_W  = 11;  // divisor: 6*(max-min) up to 1530
	localparam int DVD_W  = 18;  // dividend: 100*numerator up to 153000
	localparam int QUO_W  = 8;   // quotient bits produced by the divider
	localparam int PART_W = DVD_W - QUO_W; // dividend bits above the quotient window

	localparam int DIV_STEPS = 2; // quotient bits resolved per divider stage

	// floor(x*100/255) = (x*411220) >> 20 for x in 0..255
	localparam int                 PCT_SHIFT = 20;
	localparam logic [18:0]        PCT_MUL   = 19'd411220;
	localparam int                 PCT_PROD_W = CH_W + 19;

	// floor(sum*100/765) = (sum*2193120) >> 24 for sum in 0..765
	localparam int                 INT_SHIFT = 24;
	localparam logic [21:0]        INT_MUL   = 22'd2193120;
	localparam int                 INT_PROD_W = SUM_W + 22;

	localparam logic [DVD_W-1:0]   SCALE_100 = DVD_W'(100);
	localparam logic [QUO_W-1:0]   HUE_MAX   = QUO_W'(99);

	typedef enum logic [1:0] {
		SEL_RED,
		SEL_GREEN,
		SEL_BLUE
	} sector_t;

	// results that need no division, carried alongside the dividers
	typedef struct packed {
		logic [PCT_W-1:0] red_pct;
		logic [PCT_W-1:0] green_pct;
		logic [PCT_W-1:0] blue_pct;
		logic [PCT_W-1:0] int_pct;
		logic             gray;
	} side_t;

	typedef struct packed {
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
		logic [CH_W-1:0]  mx;
		logic [CH_W-1:0]  mn;
		logic [SUM_W-1:0] sum;
		sector_t          sel;
		side_t            side;
	} front_t;

	// partial remainder, dividend bits still to shift in / quotient bits, divisor
	typedef struct packed {
		logic [DEN_W-1:0] part;
		logic [QUO_W-1:0] acc;
		logic [DEN_W-1:0] den;
	} div_t;

	typedef struct packed {
		div_t  hue;
		div_t  sat;
		side_t side;
	} stage_t;

	// one restoring step: shift in next dividend bit, subtract if it fits
	function automatic div_t div_step(input div_t d);
		logic [DEN_W:0] sh;
		logic [DEN_W:0] diff;
		logic           fit;
		div_t           o;
		sh   = {d.part, d.acc[QUO_W-1]};
		diff = sh - {1'b0, d.den};
		fit  = (sh >= {1'b0, d.den});
		o.den  = d.den;
		o.part = fit ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
		o.acc  = {d.acc[QUO_W-2:0], fit};
		return o;
	endfunction

endpackage

`default_nettype wire

### rtl/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// Stage 1: max, min, channel sum, dominant sector, and the channel and
// intensity percentages by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_front (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [rhp_pkg::CH_W-1:0] red,
	input  wire logic [rhp_pkg::CH_W-1:0] green,
	input  wire logic [rhp_pkg::CH_W-1:0] blue,
	output rhp_pkg::front_t               front_s1
);
	import rhp_pkg::*;

	logic [CH_W-1:0]       mx;
	logic [CH_W-1:0]       mn;
	logic [SUM_W-1:0]      sum;
	sector_t               sel;
	logic [PCT_PROD_W-1:0] r_prod;
	logic [PCT_PROD_W-1:0] g_prod;
	logic [PCT_PROD_W-1:0] b_prod;
	logic [INT_PROD_W-1:0] i_prod;
	front_t                nxt;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		sum = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		// ties go to red first, then green
		if (mx == red) begin
			sel = SEL_RED;
		end else if (mx == green) begin
			sel = SEL_GREEN;
		end else begin
			sel = SEL_BLUE;
		end
	end

	assign r_prod = PCT_PROD_W'(red) * PCT_PROD_W'(PCT_MUL);
	assign g_prod = PCT_PROD_W'(green) * PCT_PROD_W'(PCT_MUL);
	assign b_prod = PCT_PROD_W'(blue) * PCT_PROD_W'(PCT_MUL);
	assign i_prod = INT_PROD_W'(sum) * INT_PROD_W'(INT_MUL);

	always_comb begin
		nxt.red            = red;
		nxt.green          = green;
		nxt.blue           = blue;
		nxt.mx             = mx;
		nxt.mn             = mn;
		nxt.sum            = sum;
		nxt.sel            = sel;
		nxt.side.red_pct   = r_prod[PCT_SHIFT +: PCT_W];
		nxt.side.green_pct = g_prod[PCT_SHIFT +: PCT_W];
		nxt.side.blue_pct  = b_prod[PCT_SHIFT +: PCT_W];
		nxt.side.int_pct   = i_prod[INT_SHIFT +: PCT_W];
		nxt.side.gray      = (mx == mn);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/rhp_prep.sv
// ----------------------------------------------------------------------------
// rhp_prep
// Stage 2: hue sector numerator and saturation numerator, scaled by 100,
// loaded into the divider operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_prep (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire rhp_pkg::front_t front_s1,
	output rhp_pkg::stage_t prep_s2
);
	import rhp_pkg::*;

	logic [DEN_W-1:0] c;
	logic [DEN_W-1:0] c6;
	logic [DEN_W-1:0] r_w;
	logic [DEN_W-1:0] g_w;
	logic [DEN_W-1:0] b_w;
	logic [DEN_W-1:0] num;
	logic [SUM_W-1:0] sat_num;
	logic [DVD_W-1:0] hue_dvd;
	logic [DVD_W-1:0] sat_dvd;
	stage_t           nxt;

	always_comb begin
		c   = DEN_W'(front_s1.mx) - DEN_W'(front_s1.mn);
		c6  = (c << 2) + (c << 1);
		r_w = DEN_W'(front_s1.red);
		g_w = DEN_W'(front_s1.green);
		b_w = DEN_W'(front_s1.blue);
		// the true numerator is in [0, 6c), so modular arithmetic is exact
		case (front_s1.sel)
			SEL_RED: begin
				if (g_w >= b_w) begin
					num = g_w - b_w;
				end else begin
					num = c6 - (b_w - g_w);
				end
			end
			SEL_GREEN: num = (c << 1) + b_w - r_w;
			SEL_BLUE:  num = (c << 2) + r_w - g_w;
			default:   num = '0;
		endcase
		sat_num = front_s1.sum - (SUM_W'(front_s1.mn) + (SUM_W'(front_s1.mn) << 1));
		hue_dvd = DVD_W'(num) * SCALE_100;
		sat_dvd = DVD_W'(sat_num) * SCALE_100;
	end

	always_comb begin
		nxt.hue.part = DEN_W'(hue_dvd[DVD_W-1:QUO_W]);
		nxt.hue.acc  = hue_dvd[QUO_W-1:0];
		nxt.hue.den  = c6;
		nxt.sat.part = DEN_W'(sat_dvd[DVD_W-1:QUO_W]);
		nxt.sat.acc  = sat_dvd[QUO_W-1:0];
		nxt.sat.den  = DEN_W'(front_s1.sum);
		nxt.side     = front_s1.side;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/rhp_div_stage.sv
// ----------------------------------------------------------------------------
// rhp_div_stage
// One stage of the two restoring dividers (hue and saturation), resolving
// a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rhp_div_stage (
	input  wire logic   clk,
	input  wire logic   en,
	input  wire rhp_pkg::stage_t stage_in,
	output rhp_pkg::stage_t stage_sx
);
	import rhp_pkg::*;

	stage_t nxt;

	always_comb begin
		nxt = stage_in;
		for (int i = 0; i < DIV_STEPS; i++) begin
			nxt.hue = div_step(nxt.hue);
			nxt.sat = div_step(nxt.sat);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_sx <= nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/rgb_to_hsi_percent.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_percent
// Throughput: one pixel per clock while result_ready does not stall the output;
// the 8-bit quotients of the hue and saturation dividers are resolved two bits
// per stage over four stages. A stalled output holds only the stages that are full;
// empty stages still fill.
// Reset clears the stage valid bits only; there is no state between pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsi_percent (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      pixel_valid,
	output logic                           pixel_ready,
	input  wire logic [rhp_pkg::CH_W-1:0]  red,
	input  wire logic [rhp_pkg::CH_W-1:0]  green,
	input  wire logic [rhp_pkg::CH_W-1:0]  blue,
	output logic                           result_valid,
	input  wire logic                      result_ready,
	output logic [rhp_pkg::PCT_W-1:0]      red_percent,
	output logic [rhp_pkg::PCT_W-1:0]      green_percent,
	output logic [rhp_pkg::PCT_W-1:0]      blue_percent,
	output logic [rhp_pkg::PCT_W-1:0]      hue_percent,
	output logic [rhp_pkg::PCT_W-1:0]      saturation_percent,
	output logic [rhp_pkg::PCT_W-1:0]      intensity_percent
);
	import rhp_pkg::*;

	localparam int NSTG = 6;

	logic [NSTG:1] vld_q;
	logic [NSTG:1] en;
	front_t        front_s1;
	stage_t        prep_s2;
	stage_t        div_s3;
	stage_t        div_s4;
	stage_t        div_s5;
	stage_t        div_s6;
	logic [QUO_W-1:0] hue_q6;

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[NSTG] = !vld_q[NSTG] || result_ready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pixel_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= pixel_valid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	rhp_front u_front (
		.clk      (clk),
		.en       (en[1]),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.front_s1 (front_s1)
	);

	rhp_prep u_prep (
		.clk      (clk),
		.en       (en[2]),
		.front_s1 (front_s1),
		.prep_s2  (prep_s2)
	);

	rhp_div_stage u_div_s3 (
		.clk      (clk),
		.en       (en[3]),
		.stage_in (prep_s2),
		.stage_sx (div_s3)
	);

	rhp_div_stage u_div_s4 (
		.clk      (clk),
		.en       (en[4]),
		.stage_in (div_s3),
		.stage_sx (div_s4)
	);

	rhp_div_stage u_div_s5 (
		.clk      (clk),
		.en       (en[5]),
		.stage_in (div_s4),
		.stage_sx (div_s5)
	);

	rhp_div_stage u_div_s6 (
		.clk      (clk),
		.en       (en[6]),
		.stage_in (div_s5),
		.stage_sx (div_s6)
	);

	assign hue_q6 = (div_s6.hue.acc > HUE_MAX) ? HUE_MAX : div_s6.hue.acc;

	assign result_valid       = vld_q[NSTG];
	assign red_percent        = div_s6.side.red_pct;
	assign green_percent      = div_s6.side.green_pct;
	assign blue_percent       = div_s6.side.blue_pct;
	assign intensity_percent  = div_s6.side.int_pct;
	// gray pixels have a zero hue divisor (black a zero saturation one too); force both to zero
	assign hue_percent        = div_s6.side.gray ? '0 : hue_q6[PCT_W-1:0];
	assign saturation_percent = div_s6.side.gray ? '0 : div_s6.sat.acc[PCT_W-1:0];

endmodule

`default_nettype wire
